### rtl/mtep_pkg.sv
`timescale 1ns / 1ps

package mtep_pkg;

  // Parser phase within one track event.
  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_MTYPE,
    PH_MLEN,
    PH_SKIP,
    PH_TEMPO
  } phase_t;

  // Sequencer around the shared divider and the result queue.
  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_DIV_BPM,
    SQ_DIV_TICK,
    SQ_EMIT
  } seq_t;

  typedef enum logic [3:0] {
    K_DELTA   = 4'd0,
    K_FWD     = 4'd1,
    K_PRESS   = 4'd2,
    K_RELEASE = 4'd3,
    K_VOLUME  = 4'd4,
    K_PAN     = 4'd5,
    K_PATCH   = 4'd6,
    K_TEMPO   = 4'd7,
    K_ERROR   = 4'd8
  } kind_t;

  // Upper nibble of a channel status byte.
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_KEY_AT   = 4'hA;
  localparam logic [3:0] MSG_CONTROL  = 4'hB;
  localparam logic [3:0] MSG_PATCH    = 4'hC;
  localparam logic [3:0] MSG_PRESSURE = 4'hD;
  localparam logic [3:0] MSG_SYSTEM   = 4'hF;

  localparam logic [7:0] META_STATUS = 8'hFF;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] TEMPO_LEN   = 8'd3;
  localparam logic [7:0] CC_VOLUME   = 8'h07;
  localparam logic [7:0] CC_PAN      = 8'h0A;
  localparam int unsigned DELTA_MAX_BYTES = 4;

  // Register map.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_CHANNEL_MASK = 1'b0;
  localparam logic REG_TICKS        = 1'b1;
  localparam logic [15:0] CHANNEL_MASK_RESET = 16'hFFFF;
  localparam logic [14:0] TICKS_RESET        = 15'd20;

  // Shared divider sizing.
  localparam int unsigned DIV_N_W   = 26;
  localparam int unsigned DIV_D_W   = 24;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W + 1);
  localparam logic [DIV_N_W-1:0] BPM_DIVIDEND = 26'd60000000;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One queued result; wide fields for delta and tempo are held apart.
  typedef struct packed {
    kind_t      kind;
    logic [3:0] channel;
    logic [7:0] data;
    logic [6:0] velocity;
  } note_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/mtep_if.sv
`timescale 1ns / 1ps

interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;

  modport source (output valid, output track_byte, input ready);
  modport sink (input valid, input track_byte, output ready);
endinterface

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [3:0]  channel;
  logic [7:0]  data;
  logic [6:0]  velocity;
  logic [27:0] delta_ticks;
  logic [25:0] beats_per_minute;
  logic [23:0] tick_length_us;
  logic        last;

  modport source (output valid, output kind, output channel, output data, output velocity,
                  output delta_ticks, output beats_per_minute, output tick_length_us,
                  output last, input ready);
  modport sink (input valid, input kind, input channel, input data, input velocity,
                input delta_ticks, input beats_per_minute, input tick_length_us,
                input last, output ready);
endinterface

### rtl/mtep_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module mtep_div (
  input  logic                clk,
  input  logic                rst,
  input  mtep_pkg::div_req_t  req,
  output mtep_pkg::div_rsp_t  rsp
);

  logic                              busy;
  logic                              done;
  logic [mtep_pkg::DIV_CNT_W-1:0]    count;
  logic [mtep_pkg::DIV_N_W-1:0]      quot;
  logic [mtep_pkg::DIV_D_W-1:0]      rem;
  logic [mtep_pkg::DIV_D_W-1:0]      divisor;
  logic [mtep_pkg::DIV_D_W:0]        rem_sh;
  logic                              ge;
  logic [mtep_pkg::DIV_D_W:0]        diff;

  always_comb begin
    rem_sh = {rem, quot[mtep_pkg::DIV_N_W-1]};
    ge     = rem_sh >= {1'b0, divisor};
    diff   = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == mtep_pkg::DIV_CNT_W'(1));
      if (req.start) begin
        busy  <= 1'b1;
        count <= mtep_pkg::DIV_CNT_W'(mtep_pkg::DIV_N_W);
      end else if (busy) begin
        count <= count - mtep_pkg::DIV_CNT_W'(1);
        if (count == mtep_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot    <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      quot <= {quot[mtep_pkg::DIV_N_W-2:0], ge};
      rem  <= ge ? diff[mtep_pkg::DIV_D_W-1:0] : rem_sh[mtep_pkg::DIV_D_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

### rtl/mtep_cfg.sv
`timescale 1ns / 1ps

// Configuration registers behind an APB-style port; writes take effect on the access beat.
module mtep_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mtep_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [15:0]                     channel_mask,
  output logic [14:0]                     ticks_per_quarter
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mask      <= mtep_pkg::CHANNEL_MASK_RESET;
      ticks_per_quarter <= mtep_pkg::TICKS_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        mtep_pkg::REG_CHANNEL_MASK: channel_mask      <= pwdata[15:0];
        mtep_pkg::REG_TICKS:        ticks_per_quarter <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mtep_pkg::REG_CHANNEL_MASK: prdata = {16'd0, channel_mask};
      mtep_pkg::REG_TICKS:        prdata = {17'd0, ticks_per_quarter};
      default:                    prdata = '0;
    endcase
  end

endmodule

### rtl/midi_track_event_parser.sv
`timescale 1ns / 1ps

// Channel     Dir  Payload
// track_in    in   track_byte[7:0]
// result_out  out  kind, channel, data, velocity, delta_ticks, beats_per_minute,
//                  tick_length_us, last
// cfg (APB)   in   channel_mask at 0x0, ticks_per_quarter at 0x4
//
// A track byte is taken when the sequencer is idle. Its results, up to four, then
// leave one per cycle through the output register while the output is not stalled.
// The final byte of a nonzero tempo runs the shared divider twice, once for each
// 26-bit quotient, before its result is loaded into the output register; the next
// byte is taken only after that load. Reset is synchronous and returns the parser to
// the start of a delta time. A stalled output beat holds the sequencer in place, while
// an idle parser still accepts.
module midi_track_event_parser (
  input  logic                            clk,
  input  logic                            rst,
  mtep_in_if.sink                         track_in,
  mtep_out_if.source                      result_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mtep_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [15:0] channel_mask;
  logic [14:0] ticks_per_quarter;

  mtep_cfg u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .channel_mask      (channel_mask),
    .ticks_per_quarter (ticks_per_quarter)
  );

  // Parser state.
  mtep_pkg::phase_t phase, phase_next;
  logic [7:0]  status_byte, status_byte_next;
  logic [7:0]  first_data, first_data_next;
  logic [27:0] delta_accumulator, delta_accumulator_next;
  logic [2:0]  delta_byte_count, delta_byte_count_next;
  logic [7:0]  meta_type, meta_type_next;
  logic [7:0]  meta_remaining, meta_remaining_next;
  logic [23:0] tempo_accumulator, tempo_accumulator_next;

  // Results of the current byte, drained one per cycle while the output register is free.
  mtep_pkg::note_t queue [mtep_pkg::QUEUE_DEPTH];
  mtep_pkg::note_t q_new [mtep_pkg::QUEUE_DEPTH];
  logic [mtep_pkg::QUEUE_CNT_W-1:0] q_cnt, q_cnt_next;
  logic [mtep_pkg::QUEUE_IDX_W-1:0] q_idx;
  logic [27:0] delta_hold, delta_hold_next;
  logic [25:0] bpm_hold;
  logic [23:0] tick_hold;
  logic        tempo_go;

  mtep_pkg::seq_t state, state_next;
  logic accept;
  logic slot_free;
  logic emit_load;
  logic emit_last;

  mtep_pkg::div_req_t div_req;
  mtep_pkg::div_rsp_t div_rsp;

  mtep_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Output register.
  logic                 out_valid;
  mtep_pkg::kind_t      out_kind;
  logic [3:0]           out_channel;
  logic [7:0]           out_data;
  logic [6:0]           out_velocity;
  logic [27:0]          out_delta;
  logic [25:0]          out_bpm;
  logic [23:0]          out_tick;
  logic                 out_last;

  assign accept    = track_in.valid && track_in.ready;
  assign slot_free = !out_valid || result_out.ready;
  assign emit_last = ({1'b0, q_idx} == (q_cnt - mtep_pkg::QUEUE_CNT_W'(1)));

  // Parse one byte: next phase and registers, plus the results it causes.
  always_comb begin
    logic [2:0]  n;
    logic [7:0]  b;
    logic [7:0]  fd;
    logic [7:0]  sec;
    logic [3:0]  hi;
    logic [3:0]  ch;
    logic        fin;
    logic [23:0] tempo_sh;

    b   = track_in.track_byte;
    n   = '0;
    fin = 1'b0;
    fd  = first_data;
    sec = '0;
    hi  = '0;
    ch  = '0;
    tempo_sh = '0;

    phase_next             = phase;
    status_byte_next       = status_byte;
    first_data_next        = first_data;
    delta_accumulator_next = delta_accumulator;
    delta_byte_count_next  = delta_byte_count;
    meta_type_next         = meta_type;
    meta_remaining_next    = meta_remaining;
    tempo_accumulator_next = tempo_accumulator;
    delta_hold_next        = delta_hold;
    tempo_go               = 1'b0;
    for (int i = 0; i < mtep_pkg::QUEUE_DEPTH; i++) begin
      q_new[i] = '0;
    end

    case (phase)
      mtep_pkg::PH_DELTA: begin
        delta_accumulator_next = {delta_accumulator[20:0], b[6:0]};
        delta_byte_count_next  = delta_byte_count + 3'd1;
        if (b[7]) begin
          if (delta_byte_count_next >= 3'(mtep_pkg::DELTA_MAX_BYTES)) begin
            q_new[0].kind = mtep_pkg::K_ERROR;
            n = 3'd1;
            delta_accumulator_next = '0;
            delta_byte_count_next  = '0;
          end
        end else begin
          q_new[0].kind   = mtep_pkg::K_DELTA;
          n               = 3'd1;
          delta_hold_next = delta_accumulator_next;
          delta_accumulator_next = '0;
          delta_byte_count_next  = '0;
          phase_next = mtep_pkg::PH_STATUS;
        end
      end
      mtep_pkg::PH_STATUS: begin
        if (b == mtep_pkg::META_STATUS) begin
          phase_next = mtep_pkg::PH_MTYPE;
        end else if (!b[7] || b[7:4] == mtep_pkg::MSG_SYSTEM ||
                     b[7:4] == mtep_pkg::MSG_PRESSURE) begin
          // Running status, channel pressure and system bytes are not followed: report and resync.
          q_new[0].kind = mtep_pkg::K_ERROR;
          n = 3'd1;
          phase_next = mtep_pkg::PH_DELTA;
        end else begin
          status_byte_next = b;
          phase_next       = mtep_pkg::PH_DATA1;
        end
      end
      mtep_pkg::PH_DATA1: begin
        first_data_next = b;
        fd              = b;
        if (status_byte[7:4] == mtep_pkg::MSG_PATCH) begin
          fin = 1'b1;
        end else begin
          phase_next = mtep_pkg::PH_DATA2;
        end
      end
      mtep_pkg::PH_DATA2: begin
        fin = 1'b1;
        sec = b;
      end
      mtep_pkg::PH_MTYPE: begin
        meta_type_next = b;
        phase_next     = mtep_pkg::PH_MLEN;
      end
      mtep_pkg::PH_MLEN: begin
        if (meta_type == mtep_pkg::META_TEMPO) begin
          if (b != mtep_pkg::TEMPO_LEN) begin
            q_new[0].kind = mtep_pkg::K_ERROR;
            n = 3'd1;
            phase_next = mtep_pkg::PH_DELTA;
          end else begin
            meta_remaining_next    = mtep_pkg::TEMPO_LEN;
            tempo_accumulator_next = '0;
            phase_next             = mtep_pkg::PH_TEMPO;
          end
        end else if (b == 8'd0) begin
          phase_next = mtep_pkg::PH_DELTA;
        end else begin
          meta_remaining_next = b;
          phase_next          = mtep_pkg::PH_SKIP;
        end
      end
      mtep_pkg::PH_SKIP: begin
        meta_remaining_next = meta_remaining - 8'd1;
        if (meta_remaining_next == 8'd0) begin
          phase_next = mtep_pkg::PH_DELTA;
        end
      end
      mtep_pkg::PH_TEMPO: begin
        tempo_sh               = {tempo_accumulator[15:0], b};
        tempo_accumulator_next = tempo_sh;
        meta_remaining_next    = meta_remaining - 8'd1;
        if (meta_remaining_next == 8'd0) begin
          q_new[0].kind = mtep_pkg::K_TEMPO;
          n = 3'd1;
          tempo_go   = (tempo_sh != 24'd0);
          phase_next = mtep_pkg::PH_DELTA;
        end
      end
      default: begin
        phase_next = mtep_pkg::PH_DELTA;
      end
    endcase

    // A complete channel message: raw bytes first when enabled, then the notification.
    if (fin) begin
      hi = status_byte[7:4];
      ch = status_byte[3:0];
      if (channel_mask[ch]) begin
        q_new[n[1:0]].kind = mtep_pkg::K_FWD;
        q_new[n[1:0]].data = status_byte;
        n = n + 3'd1;
        q_new[n[1:0]].kind = mtep_pkg::K_FWD;
        q_new[n[1:0]].data = fd;
        n = n + 3'd1;
        if (hi != mtep_pkg::MSG_PATCH) begin
          q_new[n[1:0]].kind = mtep_pkg::K_FWD;
          q_new[n[1:0]].data = sec;
          n = n + 3'd1;
        end
      end
      case (hi)
        mtep_pkg::MSG_NOTE_OFF, mtep_pkg::MSG_NOTE_ON, mtep_pkg::MSG_KEY_AT: begin
          // Note off and any zero velocity count as a release; aftertouch otherwise is quiet.
          if (hi == mtep_pkg::MSG_NOTE_OFF || sec == 8'd0) begin
            q_new[n[1:0]] = '{mtep_pkg::K_RELEASE, ch, fd, sec[6:0]};
            n = n + 3'd1;
          end else if (hi == mtep_pkg::MSG_NOTE_ON) begin
            q_new[n[1:0]] = '{mtep_pkg::K_PRESS, ch, fd, sec[6:0]};
            n = n + 3'd1;
          end
        end
        mtep_pkg::MSG_CONTROL: begin
          if (fd == mtep_pkg::CC_VOLUME) begin
            q_new[n[1:0]] = '{mtep_pkg::K_VOLUME, ch, sec, 7'd0};
            n = n + 3'd1;
          end else if (fd == mtep_pkg::CC_PAN) begin
            q_new[n[1:0]] = '{mtep_pkg::K_PAN, ch, sec, 7'd0};
            n = n + 3'd1;
          end
        end
        mtep_pkg::MSG_PATCH: begin
          q_new[n[1:0]] = '{mtep_pkg::K_PATCH, ch, fd, 7'd0};
          n = n + 3'd1;
        end
        default: ;
      endcase
      phase_next = mtep_pkg::PH_DELTA;
    end

    q_cnt_next = n;
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      mtep_pkg::SQ_IDLE: begin
        if (accept) begin
          if (tempo_go) begin
            state_next = mtep_pkg::SQ_DIV_BPM;
          end else if (q_cnt_next != '0) begin
            state_next = mtep_pkg::SQ_EMIT;
          end
        end
      end
      mtep_pkg::SQ_DIV_BPM: begin
        if (div_rsp.done) begin
          state_next = mtep_pkg::SQ_DIV_TICK;
        end
      end
      mtep_pkg::SQ_DIV_TICK: begin
        if (div_rsp.done) begin
          state_next = mtep_pkg::SQ_EMIT;
        end
      end
      mtep_pkg::SQ_EMIT: begin
        if (emit_load && emit_last) begin
          state_next = mtep_pkg::SQ_IDLE;
        end
      end
      default: state_next = mtep_pkg::SQ_IDLE;
    endcase
  end

  // Sequencer: outputs. The divider first takes 60000000 / tempo, then tempo / division.
  always_comb begin
    track_in.ready   = 1'b0;
    emit_load        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = mtep_pkg::BPM_DIVIDEND;
    div_req.divisor  = tempo_accumulator_next;
    case (state)
      mtep_pkg::SQ_IDLE: begin
        track_in.ready = 1'b1;
        div_req.start  = accept && tempo_go;
      end
      mtep_pkg::SQ_DIV_BPM: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = {2'd0, tempo_accumulator};
        // A division of zero is taken as one.
        div_req.divisor  = (ticks_per_quarter == 15'd0) ? 24'd1 : {9'd0, ticks_per_quarter};
      end
      mtep_pkg::SQ_EMIT: begin
        emit_load = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= mtep_pkg::SQ_IDLE;
      phase             <= mtep_pkg::PH_DELTA;
      status_byte       <= '0;
      first_data        <= '0;
      delta_accumulator <= '0;
      delta_byte_count  <= '0;
      meta_type         <= '0;
      meta_remaining    <= '0;
      tempo_accumulator <= '0;
      q_cnt             <= '0;
      q_idx             <= '0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        phase             <= phase_next;
        status_byte       <= status_byte_next;
        first_data        <= first_data_next;
        delta_accumulator <= delta_accumulator_next;
        delta_byte_count  <= delta_byte_count_next;
        meta_type         <= meta_type_next;
        meta_remaining    <= meta_remaining_next;
        tempo_accumulator <= tempo_accumulator_next;
        q_cnt             <= q_cnt_next;
        q_idx             <= '0;
      end else if (emit_load) begin
        q_idx <= q_idx + mtep_pkg::QUEUE_IDX_W'(1);
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      queue      <= q_new;
      delta_hold <= delta_hold_next;
      bpm_hold   <= '0;
      tick_hold  <= '0;
    end else if (div_rsp.done && state == mtep_pkg::SQ_DIV_BPM) begin
      bpm_hold <= div_rsp.quotient;
    end else if (div_rsp.done && state == mtep_pkg::SQ_DIV_TICK) begin
      tick_hold <= div_rsp.quotient[23:0];
    end
    if (emit_load) begin
      out_kind     <= queue[q_idx].kind;
      out_channel  <= queue[q_idx].channel;
      out_data     <= queue[q_idx].data;
      out_velocity <= queue[q_idx].velocity;
      out_delta    <= (queue[q_idx].kind == mtep_pkg::K_DELTA) ? delta_hold : 28'd0;
      out_bpm      <= (queue[q_idx].kind == mtep_pkg::K_TEMPO) ? bpm_hold : 26'd0;
      out_tick     <= (queue[q_idx].kind == mtep_pkg::K_TEMPO) ? tick_hold : 24'd0;
      out_last     <= emit_last;
    end
  end

  assign result_out.valid            = out_valid;
  assign result_out.kind             = out_kind;
  assign result_out.channel          = out_channel;
  assign result_out.data             = out_data;
  assign result_out.velocity         = out_velocity;
  assign result_out.delta_ticks      = out_delta;
  assign result_out.beats_per_minute = out_bpm;
  assign result_out.tick_length_us   = out_tick;
  assign result_out.last             = out_last;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the track event parser. Track bytes are pushed in on the
// track_in channel, and every beat that the parser accepts is run through a local
// decoder that keeps its own copy of the parse state and registers. The events that
// the decoder produces, or for a typed row its own event, are queued in order. Each
// result beat is then checked field by field against the oldest queued event.
module tb_top;
  import mtep_pkg::*;

  // Pitch bend has no constant of its own in the package.
  localparam logic [3:0] MSG_PITCH_BEND = 4'hE;
  // The slowest byte, the final tempo byte, needs two divider passes.
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DIR_ROWS = 30;

  // One decoded event, laid out like the result channel.
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  channel;
    logic [7:0]  data;
    logic [6:0]  velocity;
    logic [27:0] delta_ticks;
    logic [25:0] beats_per_minute;
    logic [23:0] tick_length_us;
    logic        last;
  } midi_event_t;

  // One byte of stimulus. When typed is set, the byte causes exactly one event,
  // given by kind, delta, bpm and tick, with every other field zero.
  typedef struct packed {
    logic [7:0]  value;
    logic        typed;
    kind_t       kind;
    logic [27:0] delta;
    logic [25:0] bpm;
    logic [23:0] tick;
  } track_item_t;

  localparam logic [81:0] DECODED = 82'd0;

  // Directed bytes. Rows with typed set carry an event that is plain from the
  // format: a delta, an error or a zero tempo. The others are left to the decoder.
  localparam track_item_t DIRECTED [0:DIR_ROWS-1] = '{
    // Largest one-byte delta, then a data byte where a status byte belongs.
    {8'h7F, 1'b1, K_DELTA, 28'd127, 26'd0, 24'd0},
    {8'h45, 1'b1, K_ERROR, 28'd0, 26'd0, 24'd0},
    // A fourth delta byte that still has its high bit set.
    {8'hFF, 1'b0, DECODED},
    {8'hFF, 1'b0, DECODED},
    {8'hFF, 1'b0, DECODED},
    {8'hFF, 1'b1, K_ERROR, 28'd0, 26'd0, 24'd0},
    // Largest delta of all, four bytes.
    {8'hFF, 1'b0, DECODED},
    {8'hFF, 1'b0, DECODED},
    {8'hFF, 1'b0, DECODED},
    {8'h7F, 1'b1, K_DELTA, 28'hFFFFFFF, 26'd0, 24'd0},
    // Tempo meta event whose length is not three.
    {8'hFF, 1'b0, DECODED},
    {8'h51, 1'b0, DECODED},
    {8'h02, 1'b1, K_ERROR, 28'd0, 26'd0, 24'd0},
    // Channel pressure is refused.
    {8'h00, 1'b1, K_DELTA, 28'd0, 26'd0, 24'd0},
    {8'hD5, 1'b1, K_ERROR, 28'd0, 26'd0, 24'd0},
    // A tempo of zero reports zero for both rates.
    {8'h00, 1'b1, K_DELTA, 28'd0, 26'd0, 24'd0},
    {8'hFF, 1'b0, DECODED},
    {8'h51, 1'b0, DECODED},
    {8'h03, 1'b0, DECODED},
    {8'h00, 1'b0, DECODED},
    {8'h00, 1'b0, DECODED},
    {8'h00, 1'b1, K_TEMPO, 28'd0, 26'd0, 24'd0},
    // A meta event of length zero ends at its length byte.
    {8'h00, 1'b1, K_DELTA, 28'd0, 26'd0, 24'd0},
    {8'hFF, 1'b0, DECODED},
    {8'h2F, 1'b0, DECODED},
    {8'h00, 1'b0, DECODED},
    // Note on with zero velocity counts as a key release.
    {8'h00, 1'b1, K_DELTA, 28'd0, 26'd0, 24'd0},
    {8'h93, 1'b0, DECODED},
    {8'h40, 1'b0, DECODED},
    {8'h00, 1'b0, DECODED}
  };

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  mtep_in_if  track_bus ();
  mtep_out_if result_bus ();

  midi_track_event_parser i_dut (
    .clk        (clk),
    .rst        (rst),
    .track_in   (track_bus),
    .result_out (result_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Decoder state, kept apart from the block.
  phase_t      parse_at;
  logic [7:0]  status_q;
  logic [7:0]  data1_q;
  logic [27:0] delta_acc;
  logic [2:0]  delta_cnt;
  logic [7:0]  meta_type_q;
  logic [7:0]  meta_left;
  logic [23:0] tempo_acc;
  logic [15:0] mask_cfg;
  logic [14:0] tpq_cfg;

  midi_event_t byte_events [$];    // events of the byte being decoded
  midi_event_t awaited_events [$]; // decoded events not yet seen on the output
  track_item_t byte_backlog [$];   // bytes still to be offered
  track_item_t cur_item;           // byte on the track_in channel right now

  bit steady;                      // no idling on either side while set
  bit hold_request;                // asks the receiver for one long hold-off
  int unsigned hold_left;
  int unsigned error_count;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The run is cut off if it ever hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic emit(input kind_t k, input logic [3:0] ch, input logic [7:0] d,
                      input logic [6:0] v, input logic [27:0] dt, input logic [25:0] bpm,
                      input logic [23:0] tick);
    midi_event_t ev;
    ev.kind             = k;
    ev.channel          = ch;
    ev.data             = d;
    ev.velocity         = v;
    ev.delta_ticks      = dt;
    ev.beats_per_minute = bpm;
    ev.tick_length_us   = tick;
    ev.last             = 1'b0;
    byte_events.push_back(ev);
  endtask

  // Every event boundary and every repair goes back to a fresh delta time.
  task automatic back_to_delta();
    parse_at  = PH_DELTA;
    delta_acc = '0;
    delta_cnt = '0;
  endtask

  task automatic flag_error();
    back_to_delta();
    emit(K_ERROR, 4'd0, 8'd0, 7'd0, 28'd0, 26'd0, 24'd0);
  endtask

  // A channel message is complete: forward its bytes when the channel is enabled,
  // then add the notification, which does not depend on the mask.
  task automatic complete_message(input logic [7:0] second);
    logic [3:0] ch;
    logic [3:0] hi;
    ch = status_q[3:0];
    hi = status_q[7:4];
    if (mask_cfg[ch]) begin
      emit(K_FWD, 4'd0, status_q, 7'd0, 28'd0, 26'd0, 24'd0);
      emit(K_FWD, 4'd0, data1_q, 7'd0, 28'd0, 26'd0, 24'd0);
      if (hi != MSG_PATCH) emit(K_FWD, 4'd0, second, 7'd0, 28'd0, 26'd0, 24'd0);
    end
    if (hi == MSG_NOTE_OFF || hi == MSG_NOTE_ON || hi == MSG_KEY_AT) begin
      // Aftertouch with a nonzero pressure tells nothing.
      if (hi == MSG_NOTE_OFF || second == 8'd0) begin
        emit(K_RELEASE, ch, data1_q, second[6:0], 28'd0, 26'd0, 24'd0);
      end else if (hi == MSG_NOTE_ON) begin
        emit(K_PRESS, ch, data1_q, second[6:0], 28'd0, 26'd0, 24'd0);
      end
    end else if (hi == MSG_CONTROL) begin
      if (data1_q == CC_VOLUME) begin
        emit(K_VOLUME, ch, second, 7'd0, 28'd0, 26'd0, 24'd0);
      end else if (data1_q == CC_PAN) begin
        emit(K_PAN, ch, second, 7'd0, 28'd0, 26'd0, 24'd0);
      end
    end else if (hi == MSG_PATCH) begin
      emit(K_PATCH, ch, data1_q, 7'd0, 28'd0, 26'd0, 24'd0);
    end
    back_to_delta();
  endtask

  // Decodes one accepted track byte into byte_events, the last one marked.
  task automatic decode_track_byte(input logic [7:0] b);
    midi_event_t tail;
    int unsigned tempo_u;
    int unsigned div_u;
    byte_events.delete();
    case (parse_at)
      PH_DELTA: begin
        delta_acc = {delta_acc[20:0], b[6:0]};
        delta_cnt = delta_cnt + 3'd1;
        if (b[7]) begin
          if (delta_cnt >= 3'(DELTA_MAX_BYTES)) flag_error();
        end else begin
          emit(K_DELTA, 4'd0, 8'd0, 7'd0, delta_acc, 26'd0, 24'd0);
          delta_acc = '0;
          delta_cnt = '0;
          parse_at  = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b == META_STATUS) begin
          parse_at = PH_MTYPE;
        end else if (!b[7] || b[7:4] == MSG_SYSTEM || b[7:4] == MSG_PRESSURE) begin
          flag_error();
        end else begin
          status_q = b;
          parse_at = PH_DATA1;
        end
      end
      PH_DATA1: begin
        data1_q = b;
        if (status_q[7:4] == MSG_PATCH) complete_message(8'd0);
        else parse_at = PH_DATA2;
      end
      PH_DATA2: complete_message(b);
      PH_MTYPE: begin
        meta_type_q = b;
        parse_at    = PH_MLEN;
      end
      PH_MLEN: begin
        if (meta_type_q == META_TEMPO) begin
          if (b != TEMPO_LEN) begin
            flag_error();
          end else begin
            meta_left = TEMPO_LEN;
            tempo_acc = '0;
            parse_at  = PH_TEMPO;
          end
        end else if (b == 8'd0) begin
          back_to_delta();
        end else begin
          meta_left = b;
          parse_at  = PH_SKIP;
        end
      end
      PH_SKIP: begin
        meta_left = meta_left - 8'd1;
        if (meta_left == 8'd0) back_to_delta();
      end
      PH_TEMPO: begin
        tempo_acc = {tempo_acc[15:0], b};
        meta_left = meta_left - 8'd1;
        if (meta_left == 8'd0) begin
          tempo_u = tempo_acc;
          // A division of zero is taken as one.
          div_u = (tpq_cfg == 15'd0) ? 1 : tpq_cfg;
          if (tempo_u == 0) begin
            emit(K_TEMPO, 4'd0, 8'd0, 7'd0, 28'd0, 26'd0, 24'd0);
          end else begin
            emit(K_TEMPO, 4'd0, 8'd0, 7'd0, 28'd0, 26'(60000000 / tempo_u),
                 24'(tempo_u / div_u));
          end
          back_to_delta();
        end
      end
      default: back_to_delta();
    endcase
    if (byte_events.size() > 0) begin
      tail      = byte_events.pop_back();
      tail.last = 1'b1;
      byte_events.push_back(tail);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      error_count++;
    end
  endtask

  // Both channels are sampled at the rising edge. Accepted input beats are decoded
  // first, so that a result never finds its expectation missing.
  always @(posedge clk) begin
    midi_event_t want;
    if (!rst) begin
      if (track_bus.valid && track_bus.ready) begin
        decode_track_byte(cur_item.value);
        if (cur_item.typed) begin
          want                  = '0;
          want.kind             = cur_item.kind;
          want.delta_ticks      = cur_item.delta;
          want.beats_per_minute = cur_item.bpm;
          want.tick_length_us   = cur_item.tick;
          want.last             = 1'b1;
          awaited_events.push_back(want);
        end else begin
          foreach (byte_events[i]) awaited_events.push_back(byte_events[i]);
        end
      end
      if (result_bus.valid && result_bus.ready) begin
        if (awaited_events.size() == 0) begin
          $error("result beat with nothing expected, kind 0x%0h", result_bus.kind);
          error_count++;
        end else begin
          want = awaited_events.pop_front();
          check_field("kind", want.kind, result_bus.kind);
          check_field("channel", want.channel, result_bus.channel);
          check_field("data", want.data, result_bus.data);
          check_field("velocity", want.velocity, result_bus.velocity);
          check_field("delta_ticks", want.delta_ticks, result_bus.delta_ticks);
          check_field("beats_per_minute", want.beats_per_minute,
                      result_bus.beats_per_minute);
          check_field("tick_length_us", want.tick_length_us, result_bus.tick_length_us);
          check_field("last", want.last, result_bus.last);
        end
      end
    end
  end

  // The receiver drops ready about a third of the time unless steady is set. On request it holds off
  // for a long stretch, counted here, so the parser fills up and stalls its input.
  initial begin
    result_bus.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (!steady && $urandom_range(99) < 33) begin
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  task automatic add_byte(input logic [7:0] b);
    byte_backlog.push_back({b, 1'b0, DECODED});
  endtask

  // Builds mostly well-formed events with random content, mixed with every kind
  // of repair and some raw noise that can land the parser in any phase.
  task automatic build_random(input int n_bytes);
    int          base;
    int          pick;
    int          nb;
    logic [3:0]  hi;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [23:0] t;
    base = byte_backlog.size();
    while (byte_backlog.size() - base < n_bytes) begin
      if ($urandom_range(99) < 5) begin
        // Delta that runs past four bytes.
        repeat (4) add_byte(8'h80 | 8'($urandom_range(127)));
      end else begin
        nb = ($urandom_range(99) < 70) ? 1 : $urandom_range(4, 2);
        repeat (nb - 1) add_byte(8'h80 | 8'($urandom_range(127)));
        add_byte(8'($urandom_range(127)));
        pick = $urandom_range(99);
        if (pick < 55) begin
          case ($urandom_range(5))
            0: hi = MSG_NOTE_OFF;
            1: hi = MSG_NOTE_ON;
            2: hi = MSG_KEY_AT;
            3: hi = MSG_CONTROL;
            4: hi = MSG_PATCH;
            default: hi = MSG_PITCH_BEND;
          endcase
          d1 = 8'($urandom_range(255));
          if (hi == MSG_CONTROL && $urandom_range(1) == 1) begin
            d1 = ($urandom_range(1) == 1) ? CC_VOLUME : CC_PAN;
          end
          d2 = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(255));
          add_byte({hi, 4'($urandom_range(15))});
          add_byte(d1);
          if (hi != MSG_PATCH) add_byte(d2);
        end else if (pick < 67) begin
          case ($urandom_range(9))
            0: t = 24'd0;
            1: t = 24'hFFFFFF;
            2: t = 24'd1;
            default: t = 24'($urandom);
          endcase
          add_byte(META_STATUS);
          add_byte(META_TEMPO);
          add_byte(TEMPO_LEN);
          add_byte(t[23:16]);
          add_byte(t[15:8]);
          add_byte(t[7:0]);
        end else if (pick < 77) begin
          d1 = 8'($urandom_range(255));
          if (d1 == META_TEMPO) d1 = 8'h2F;
          nb = $urandom_range(5);
          add_byte(META_STATUS);
          add_byte(d1);
          add_byte(8'(nb));
          repeat (nb) add_byte(8'($urandom_range(255)));
        end else if (pick < 82) begin
          d1 = 8'($urandom_range(255));
          if (d1 == TEMPO_LEN) d1 = 8'd0;
          add_byte(META_STATUS);
          add_byte(META_TEMPO);
          add_byte(d1);
        end else if (pick < 87) begin
          add_byte(8'($urandom_range(127)));
        end else if (pick < 92) begin
          if ($urandom_range(1) == 1) add_byte(8'($urandom_range(254, 240)));
          else add_byte({MSG_PRESSURE, 4'($urandom_range(15))});
        end else begin
          repeat ($urandom_range(3, 1)) add_byte(8'($urandom_range(255)));
        end
      end
    end
  endtask

  // Offers the backlog one beat at a time with random gaps. After pause_at beats
  // the sender waits until every decoded event has come out.
  task automatic offer_bytes(input int pause_at);
    int sent;
    sent = 0;
    while (byte_backlog.size() > 0) begin
      @(negedge clk);
      if (sent == pause_at) begin
        track_bus.valid <= 1'b0;
        while (awaited_events.size() != 0) @(negedge clk);
        pause_at = -1;
      end else if (!steady && $urandom_range(99) < 33) begin
        track_bus.valid <= 1'b0;
      end else begin
        cur_item = byte_backlog.pop_front();
        track_bus.valid      <= 1'b1;
        track_bus.track_byte <= cur_item.value;
        @(posedge clk);
        while (!track_bus.ready) @(posedge clk);
        sent++;
      end
    end
    @(negedge clk);
    track_bus.valid <= 1'b0;
  endtask

  // Waits for every decoded event, then lets the parser settle.
  task automatic wait_quiet();
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value at
  // the edge where the access completes.
  task automatic cfg_write(input logic reg_index, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({reg_index, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_index == REG_CHANNEL_MASK) mask_cfg = value[15:0];
    else tpq_cfg = value[14:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    track_bus.valid      = 1'b0;
    track_bus.track_byte = 8'd0;
    cur_item             = '0;
    steady               = 1'b0;
    hold_request         = 1'b0;
    error_count          = 0;
    cycle_count          = 0;
    mask_cfg             = CHANNEL_MASK_RESET;
    tpq_cfg              = TICKS_RESET;
    status_q             = '0;
    data1_q              = '0;
    meta_type_q          = '0;
    meta_left            = '0;
    tempo_acc            = '0;
    back_to_delta();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed bytes under the reset register values.
    for (int i = 0; i < DIR_ROWS; i++) byte_backlog.push_back(DIRECTED[i]);
    offer_bytes(-1);
    wait_quiet();

    // Every channel masked and the smallest division; the sender pauses midway
    // until the output has drained.
    cfg_write(REG_CHANNEL_MASK, 32'h0000);
    cfg_write(REG_TICKS, 32'd1);
    build_random(120);
    offer_bytes(60);
    wait_quiet();

    // Every channel enabled and the largest division, with a long receiver hold.
    cfg_write(REG_CHANNEL_MASK, 32'hFFFF);
    cfg_write(REG_TICKS, 32'd32767);
    hold_request = 1'b1;
    build_random(120);
    offer_bytes(-1);
    wait_quiet();

    // A division of zero, which the parser treats as one.
    cfg_write(REG_CHANNEL_MASK, 32'($urandom_range(16'hFFFF)));
    cfg_write(REG_TICKS, 32'd0);
    build_random(120);
    offer_bytes(-1);
    wait_quiet();

    // Random settings and a stretch with no idling on either side.
    cfg_write(REG_CHANNEL_MASK, 32'($urandom_range(16'hFFFF)));
    cfg_write(REG_TICKS, 32'($urandom_range(32767, 1)));
    steady = 1'b1;
    build_random(140);
    offer_bytes(-1);
    wait_quiet();
    steady = 1'b0;

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/mtep_pkg.sv
rtl/mtep_if.sv
rtl/mtep_div.sv
rtl/mtep_cfg.sv
rtl/midi_track_event_parser.sv
dv/tb_top.sv
